FILE: sv/ccdg_pkg.sv
package ccdg_pkg;

	// effective frame size saturates here
	localparam int MAX_DIM = 4096;
	localparam int DIM_W = 14;

	localparam int TRIG_FRACTION_BITS = 24;
	localparam int TRIG_MAX_BITS = 32;

	// cos table covers 0 to 90 degrees
	localparam int COS_TAB_LEN = 91;
	localparam int ANG_W = 7;
	localparam int RADIUS_W = 15;
	localparam int LIMIT_W = 14;
	localparam int COORD_W = 12;

	localparam logic [ANG_W-1:0] ANG_FIRST = 7'd1;
	localparam logic [ANG_W-1:0] ANG_LAST = 7'd89;
	localparam logic [ANG_W-1:0] ANG_WRAP = 7'd90;
	localparam logic [2:0] LVL_MIN = 3'd1;
	localparam logic [2:0] LVL_MAX = 3'd4;
	localparam logic [2:0] LVL_BASE = 3'd6;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 14;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_FRAME_WIDTH  = 3'd2,
		REG_FRAME_HEIGHT = 3'd3,
		REG_HL_DIAMETER  = 3'd4,
		REG_RING_INT     = 3'd5,
		REG_DOT_LEVEL    = 3'd6
	} cfg_reg_t;

	// absolute value of a 16-bit signed distance
	function automatic logic [15:0] abs16(logic signed [15:0] v);
		abs16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	// cos(a degrees) with fbits fraction bits, from a Q62 taylor series,
	// rounded to nearest; only evaluated on constants at elaboration
	function automatic logic [TRIG_MAX_BITS:0] cos_calc(int a, int fbits);
		logic [63:0] rpd;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		logic [127:0] p;
		logic [63:0] rnd;
		int k;
		rpd = 64'hC90FDAA22168C235 / 64'd180;
		x = rpd * 64'(a);
		p = {64'd0, x} * {64'd0, x};
		x2 = p[125:62];
		term = 64'd1 << 62;
		sum = term;
		for (k = 1; k <= 13; k++) begin
			p = {64'd0, term} * {64'd0, x2};
			q = p[125:62];
			term = q / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		rnd = 64'd1 << (61 - fbits);
		q = (sum + rnd) >> (62 - fbits);
		cos_calc = q[TRIG_MAX_BITS:0];
	endfunction

endpackage

FILE: sv/concentric_circle_dot_generator_core.sv
// pipeline: an accepted request passes three register stages (table read, multiply,
// output register) to the outputs; the sequencer steps once per request
// throughput: one request per cycle unless m_tready stalls the output; the cos
// table read and the two radius multipliers are each one pipeline stage
// reset: arst_n clears the sequencer to the finished state and empties the
// pipeline; registers return to their defaults, no clearing pass is needed
module concentric_circle_dot_generator_core
	import ccdg_pkg::*;
#(
	parameter int TRIG_FRAC = TRIG_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [11:0] dot_x, [23:12] dot_y
	output logic [1:0]            m_tuser,   // [0] dot_valid, [1] on_highlight_ring
	output logic                  m_tlast    // pattern_done
);

	localparam int CW = TRIG_FRAC + 1;
	localparam int PW = RADIUS_W + CW;

	// configuration registers
	logic signed [13:0] origin_x_q, origin_y_q;
	logic [12:0] frame_w_q, frame_h_q;
	logic [13:0] hl_diam_q;
	logic [11:0] ring_int_q;
	logic [2:0] dot_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 14'sd960;
			origin_y_q <= 14'sd540;
			frame_w_q <= 13'd1920;
			frame_h_q <= 13'd1080;
			hl_diam_q <= 14'd2160;
			ring_int_q <= 12'd50;
			dot_lvl_q <= 3'd2;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ORIGIN_X: origin_x_q <= $signed(cfg_wdata[13:0]);
				REG_ORIGIN_Y: origin_y_q <= $signed(cfg_wdata[13:0]);
				REG_FRAME_WIDTH: frame_w_q <= cfg_wdata[12:0];
				REG_FRAME_HEIGHT: frame_h_q <= cfg_wdata[12:0];
				REG_HL_DIAMETER: hl_diam_q <= cfg_wdata[13:0];
				REG_RING_INT: ring_int_q <= cfg_wdata[11:0];
				REG_DOT_LEVEL: dot_lvl_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] eff_w, eff_h;
	assign eff_w = ({1'b0, frame_w_q} > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : {1'b0, frame_w_q};
	assign eff_h = ({1'b0, frame_h_q} > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : {1'b0, frame_h_q};

	// constant cos table
	logic [CW-1:0] cos_tab [0:COS_TAB_LEN-1];
	for (genvar i = 0; i < COS_TAB_LEN; i++) begin : g_cos
		localparam logic [TRIG_MAX_BITS:0] CV = cos_calc(i, TRIG_FRAC);
		assign cos_tab[i] = CV[CW-1:0];
	end

	// pipeline flow control, each stage moves when the next has room
	logic v_s1, v_s2;
	logic adv1, adv2, adv3;
	assign adv3 = !m_tvalid || m_tready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	logic accept;
	assign accept = s_tvalid && s_tready;

	// sequencer state
	logic [RADIUS_W-1:0] ring_radius_q;
	logic [LIMIT_W-1:0] ring_limit_q;
	logic [ANG_W-1:0] angle_q;
	logic [1:0] quad_q;
	logic finished_q;

	logic restart;
	assign restart = s_tdata[0];

	// ring limit: farthest frame edge from the origin
	logic [15:0] d_y0, d_y1, d_x0, d_x1, m_a, m_b, m_lim;
	assign d_y0 = abs16(16'(origin_y_q) - $signed({2'b00, eff_h}));
	assign d_y1 = abs16(16'(origin_y_q));
	assign d_x0 = abs16(16'(origin_x_q) - $signed({2'b00, eff_w}));
	assign d_x1 = abs16(16'(origin_x_q));
	assign m_a = (d_y1 > d_y0) ? d_y1 : d_y0;
	assign m_b = (d_x1 > d_x0) ? d_x1 : d_x0;
	assign m_lim = (m_b > m_a) ? m_b : m_a;

	logic [RADIUS_W-1:0] rr_cur, r_cur, rr_nx;
	logic [LIMIT_W-1:0] lim_cur;
	logic [ANG_W-1:0] ang_cur, a_cl, a_sum, ang_nx;
	logic [1:0] q_cur;
	logic fin_cur;
	logic [2:0] lvl, inc;
	logic [11:0] step;
	logic [RADIUS_W:0] rr_sum;
	logic wrap, last;

	always_comb begin
		rr_cur = restart ? '0 : ring_radius_q;
		ang_cur = restart ? ANG_FIRST : angle_q;
		q_cur = restart ? 2'd0 : quad_q;
		fin_cur = restart ? 1'b0 : finished_q;
		lim_cur = restart ? m_lim[LIMIT_W-1:0] : ring_limit_q;
		a_cl = (ang_cur < ANG_FIRST || ang_cur > ANG_LAST) ? ANG_FIRST : ang_cur;
		lvl = (dot_lvl_q < LVL_MIN) ? LVL_MIN : ((dot_lvl_q > LVL_MAX) ? LVL_MAX : dot_lvl_q);
		step = (ring_int_q == '0) ? 12'd1 : ring_int_q;
		inc = (rr_cur == '0) ? 3'd1 : LVL_BASE - lvl;
		r_cur = (rr_cur == '0) ? {2'b00, hl_diam_q[13:1]} : rr_cur;
		a_sum = a_cl + {4'd0, inc};
		rr_sum = {1'b0, rr_cur} + {4'd0, step};
		wrap = (q_cur == 2'd3) && (a_sum >= ANG_WRAP);
		ang_nx = (q_cur == 2'd3) ? (wrap ? ANG_FIRST : a_sum) : a_cl;
		rr_nx = wrap ? rr_sum[RADIUS_W-1:0] : rr_cur;
		last = wrap && (rr_nx > {1'b0, lim_cur});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q <= '0;
			ring_limit_q <= '0;
			angle_q <= ANG_FIRST;
			quad_q <= 2'd0;
			finished_q <= 1'b1;
		end else if (accept) begin
			if (restart) begin
				ring_limit_q <= m_lim[LIMIT_W-1:0];
			end
			if (!fin_cur) begin
				ring_radius_q <= rr_nx;
				angle_q <= ang_nx;
				quad_q <= q_cur + 2'd1;
				finished_q <= last;
			end
		end
	end

	// stage 1: table read
	logic idle_s1, hl_s1, last_s1;
	logic [1:0] q_s1;
	logic [RADIUS_W-1:0] r_s1;
	logic [CW-1:0] cos_a_s1, cos_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && accept) begin
			idle_s1 <= fin_cur;
			hl_s1 <= (rr_cur == '0);
			last_s1 <= last;
			q_s1 <= q_cur;
			r_s1 <= r_cur;
			cos_a_s1 <= cos_tab[a_cl];
			cos_b_s1 <= cos_tab[ANG_WRAP - a_cl];
		end
	end

	// stage 2: radius times cos and sin
	logic [PW-1:0] prod_x, prod_y;
	assign prod_x = {{CW{1'b0}}, r_s1} * {{RADIUS_W{1'b0}}, cos_a_s1};
	assign prod_y = {{CW{1'b0}}, r_s1} * {{RADIUS_W{1'b0}}, cos_b_s1};

	logic idle_s2, hl_s2, last_s2;
	logic [1:0] q_s2;
	logic [RADIUS_W-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			idle_s2 <= idle_s1;
			hl_s2 <= hl_s1;
			last_s2 <= last_s1;
			q_s2 <= q_s1;
			dx_s2 <= prod_x[TRIG_FRAC +: RADIUS_W];
			dy_s2 <= prod_y[TRIG_FRAC +: RADIUS_W];
		end
	end

	// stage 3: place in quadrant, clip, output register
	logic signed [16:0] w_pos, h_pos;
	logic in_frame;

	always_comb begin
		w_pos = q_s2[0] ? 17'(origin_x_q) + $signed({2'b00, dx_s2})
		                : 17'(origin_x_q) - $signed({2'b00, dx_s2});
		h_pos = q_s2[1] ? 17'(origin_y_q) + $signed({2'b00, dy_s2})
		                : 17'(origin_y_q) - $signed({2'b00, dy_s2});
		in_frame = !idle_s2 && !w_pos[16] && !h_pos[16]
			&& (w_pos < $signed({3'b000, eff_w})) && (h_pos < $signed({3'b000, eff_h}));
	end

	logic m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv3) begin
			m_tvalid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			m_tdata_q <= in_frame ? {h_pos[COORD_W-1:0], w_pos[COORD_W-1:0]} : '0;
			m_tuser_q <= {hl_s2 && !idle_s2, in_frame};
			m_tlast_q <= idle_s2 || last_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

endmodule

FILE: bench/concentric_circle_dot_generator_core_test.sv
module concentric_circle_dot_generator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ccdg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_COUNT = 1150;
	// first ring plus two ordinary rings plus the trailing idle requests
	localparam int PATTERN_MAX = 740;

	typedef struct packed {
		logic [13:0] org_x;
		logic [13:0] org_y;
		logic [12:0] width;
		logic [12:0] height;
		logic [13:0] diameter;
		logic [11:0] interval;
		logic [2:0]  level;
	} ring_cfg_t;

	typedef struct packed {
		logic               in_frame;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               first_ring;
		logic               done;
	} dot_t;

	class dot_scoreboard;
		longint unsigned cos_q [COS_TAB_LEN];
		ring_cfg_t cfg;
		logic [RADIUS_W-1:0] radius;
		logic [LIMIT_W-1:0] limit;
		logic [ANG_W-1:0] angle;
		logic [1:0] quad;
		logic finished;
		dot_t pending_dots [$];
		int errors;
		int compared;
		int in_frame;
		int first_ring;
		int patterns;

		function new();
			logic [63:0] deg;
			logic [63:0] x;
			logic [63:0] x2;
			logic [63:0] term;
			logic [63:0] sum;
			logic [127:0] p;
			// pi/180 in q62
			deg = 64'hC90FDAA22168C235 / 64'd180;
			for (int a = 0; a < COS_TAB_LEN; a++) begin
				x = deg * 64'(a);
				p = {64'd0, x} * {64'd0, x};
				x2 = p[125:62];
				term = 64'd1 << 62;
				sum = term;
				for (int k = 1; k <= 13; k++) begin
					p = {64'd0, term} * {64'd0, x2};
					term = p[125:62] / 64'((2 * k - 1) * (2 * k));
					sum = (k % 2 == 1) ? sum - term : sum + term;
				end
				cos_q[a] = (sum + (64'd1 << (61 - TRIG_FRACTION_BITS))) >>
					(62 - TRIG_FRACTION_BITS);
			end
			cfg = '{org_x: 14'd960, org_y: 14'd540, width: 13'd1920, height: 13'd1080,
				diameter: 14'd2160, interval: 12'd50, level: 3'd2};
			radius = '0;
			limit = '0;
			angle = ANG_FIRST;
			quad = '0;
			finished = 1'b1;
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		function dot_t next_dot(logic restart);
			int wd;
			int ht;
			int ox;
			int oy;
			int lim;
			int lvl;
			int stride;
			int inc;
			int r;
			int a;
			int w;
			int h;
			longint unsigned dx;
			longint unsigned dy;
			dot_t d;
			wd = (cfg.width > MAX_DIM) ? MAX_DIM : int'(cfg.width);
			ht = (cfg.height > MAX_DIM) ? MAX_DIM : int'(cfg.height);
			ox = int'($signed(cfg.org_x));
			oy = int'($signed(cfg.org_y));
			d = '0;
			if (restart) begin
				// ring limit is the farthest frame edge, latched here only
				lim = magnitude(oy - ht);
				if (magnitude(oy) > lim) lim = magnitude(oy);
				if (magnitude(ox - wd) > lim) lim = magnitude(ox - wd);
				if (magnitude(ox) > lim) lim = magnitude(ox);
				limit = LIMIT_W'(lim);
				radius = '0;
				angle = ANG_FIRST;
				quad = '0;
				finished = 1'b0;
			end
			if (finished) begin
				d.done = 1'b1;
				return d;
			end
			lvl = (cfg.level < LVL_MIN) ? LVL_MIN : ((cfg.level > LVL_MAX) ? LVL_MAX : cfg.level);
			stride = (cfg.interval == 0) ? 1 : int'(cfg.interval);
			inc = (radius == 0) ? 1 : int'(LVL_BASE) - lvl;
			r = (radius == 0) ? int'(cfg.diameter) / 2 : int'(radius);
			a = angle;
			if (a < ANG_FIRST || a > ANG_LAST) a = ANG_FIRST;
			dx = (64'(r) * cos_q[a]) >> TRIG_FRACTION_BITS;
			dy = (64'(r) * cos_q[90 - a]) >> TRIG_FRACTION_BITS;
			w = quad[0] ? ox + int'(dx) : ox - int'(dx);
			h = quad[1] ? oy + int'(dy) : oy - int'(dy);
			d.in_frame = (w >= 0) && (w < wd) && (h >= 0) && (h < ht);
			if (d.in_frame) begin
				d.x = COORD_W'(w);
				d.y = COORD_W'(h);
			end
			d.first_ring = (radius == 0);
			quad = quad + 2'd1;
			if (quad == 0) begin
				a = a + inc;
				if (a >= ANG_WRAP) begin
					a = ANG_FIRST;
					radius = RADIUS_W'(radius + stride);
					if (radius > limit) begin
						d.done = 1'b1;
						patterns++;
					end
				end
			end
			angle = ANG_W'(a);
			finished = d.done;
			return d;
		endfunction

		function void note_request(logic restart);
			pending_dots.push_back(next_dot(restart));
		endfunction

		function void check_dot(dot_t got);
			dot_t want;
			if (pending_dots.size() == 0) begin
				$error("dot result with no request pending");
				errors++;
				return;
			end
			want = pending_dots.pop_front();
			compared++;
			if (want.in_frame) in_frame++;
			if (want.first_ring) first_ring++;
			if (got.in_frame !== want.in_frame) begin
				$error("dot_valid: expected %0d, got %0d", want.in_frame, got.in_frame);
				errors++;
			end
			if (got.x !== want.x) begin
				$error("dot_x: expected %0d, got %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("dot_y: expected %0d, got %0d", want.y, got.y);
				errors++;
			end
			if (got.first_ring !== want.first_ring) begin
				$error("on_highlight_ring: expected %0d, got %0d", want.first_ring,
					got.first_ring);
				errors++;
			end
			if (got.done !== want.done) begin
				$error("pattern_done: expected %0d, got %0d", want.done, got.done);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	int cycles = 0;
	int sent = 0;
	int settings = 0;
	logic calm;
	dot_scoreboard board;

	concentric_circle_dot_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stretch with no idling on either side
	assign calm = (cycles >= 400) && (cycles < 1000);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_dot(dot_t'{in_frame: m_tuser[0], x: m_tdata[11:0], y: m_tdata[23:12],
				first_ring: m_tuser[1], done: m_tlast});
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input logic restart);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		board.note_request(restart);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending_dots.size() != 0);
	endtask

	task automatic apply_config(input ring_cfg_t c);
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we <= 1'b1;
			cfg_addr <= r;
			case (r)
				REG_ORIGIN_X:     cfg_wdata <= c.org_x;
				REG_ORIGIN_Y:     cfg_wdata <= c.org_y;
				REG_FRAME_WIDTH:  cfg_wdata <= CFG_DATA_W'(c.width);
				REG_FRAME_HEIGHT: cfg_wdata <= CFG_DATA_W'(c.height);
				REG_HL_DIAMETER:  cfg_wdata <= c.diameter;
				REG_RING_INT:     cfg_wdata <= CFG_DATA_W'(c.interval);
				default:          cfg_wdata <= CFG_DATA_W'(c.level);
			endcase
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
		board.cfg = c;
		settings++;
	endtask

	initial begin
		ring_cfg_t c;
		int len;
		int span;
		int stride;
		int phase;
		board = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks before any restart, then a few dots at the reset settings
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// zero-sized frame: nothing lands inside but the sequence still steps
		c = '{org_x: 14'd0, org_y: 14'd0, width: 13'd0, height: 13'd0,
			diameter: 14'd16382, interval: 12'd10, level: 3'd1};
		apply_config(c);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		// oversized frame saturates, zero interval and level, restart mid-ring
		c = '{org_x: 14'h2000, org_y: 14'h1FFF, width: 13'h1FFF, height: 13'h1FFF,
			diameter: 14'h3FFF, interval: 12'd0, level: 3'd0};
		apply_config(c);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		c = '{org_x: 14'h1FFF, org_y: 14'h2000, width: 13'd4096, height: 13'd4097,
			diameter: 14'd128, interval: 12'hFFF, level: 3'd7};
		apply_config(c);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		// zero diameter puts the first dots on the centre
		c = '{org_x: 14'd100, org_y: 14'd100, width: 13'd200, height: 13'd200,
			diameter: 14'd0, interval: 12'd2048, level: 3'd5};
		apply_config(c);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		c = '{org_x: 14'd0, org_y: 14'd0, width: 13'd1, height: 13'd1,
			diameter: 14'd1, interval: 12'd10, level: 3'd6};
		apply_config(c);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		phase = 0;
		while (sent < ITEM_COUNT) begin
			if (phase % 3 == 0 && sent + PATTERN_MAX < ITEM_COUNT) begin
				// frame within two ring intervals so the pattern ends soon
				case ($urandom_range(9))
					0:       c.interval = 12'd0;
					1:       c.interval = 12'hFFF;
					default: c.interval = 12'($urandom_range(10, 2048));
				endcase
				stride = (c.interval == 0) ? 1 : int'(c.interval);
				span = (2 * stride > MAX_DIM) ? MAX_DIM : 2 * stride;
				c.width = 13'($urandom_range(1, span));
				c.height = 13'($urandom_range(1, span));
				c.org_x = 14'($urandom_range(0, c.width));
				c.org_y = 14'($urandom_range(0, c.height));
				c.diameter = 14'($urandom_range(0, (4 * span > 16383) ? 16383 : 4 * span));
				c.level = 3'($urandom);
				apply_config(c);
				send_item(1'b1);
				while (!board.finished) send_item(1'b0);
				repeat ($urandom_range(1, 6)) send_item(1'b0);
			end else begin
				c.width = ($urandom_range(2) == 0) ? 13'($urandom) :
					13'($urandom_range(1, MAX_DIM));
				c.height = ($urandom_range(2) == 0) ? 13'($urandom) :
					13'($urandom_range(1, MAX_DIM));
				c.org_x = ($urandom_range(2) == 0) ? 14'($urandom) :
					14'($urandom_range(0, c.width));
				c.org_y = ($urandom_range(2) == 0) ? 14'($urandom) :
					14'($urandom_range(0, c.height));
				c.diameter = 14'($urandom);
				c.interval = 12'($urandom);
				c.level = 3'($urandom);
				len = $urandom_range(30, 150);
				if (len > ITEM_COUNT - sent) len = ITEM_COUNT - sent;
				apply_config(c);
				send_item(1'b1);
				for (int k = 1; k < len; k++) begin
					// hold requests once until the pipeline is empty
					if (phase == 1 && k == len / 2) drain();
					send_item($urandom_range(49) == 0);
				end
			end
			drain();
			phase++;
		end

		repeat (8) @(posedge clk);
		$display("%0d requests under %0d register settings, %0d dots compared", sent,
			settings, board.compared);
		$display("%0d dots inside the frame, %0d on the first ring, %0d patterns completed",
			board.in_frame, board.first_ring, board.patterns);
		if (board.errors == 0 && board.pending_dots.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
